[rtl/sbp_pkg.sv]
// Shared constants and controller/datapath interface types for the
// seven-bit packing decoder. No dependencies.
package sbp_pkg;

    localparam int GROUP_SIZE = 7;
    localparam int BYTE_W     = 8;
    localparam int DATA_W     = 7;
    localparam int COUNT_W    = 3;

    typedef struct packed {
        logic store_byte;
        logic start_drain;
        logic emit;
        logic clear_count;
    } sbp_cmd_t;

    typedef struct packed {
        logic group_close;
        logic count_zero;
        logic emit_last;
        logic out_slot_free;
    } sbp_status_t;

endpackage

[rtl/sbp_ctrl.sv]
// Controller for the seven-bit packing decoder: collect and drain phases.
// Depends on sbp_pkg.
module sbp_ctrl
    import sbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  sbp_status_t status,
    output sbp_cmd_t    cmd
);

    localparam logic ST_COLLECT = 1'b0;
    localparam logic ST_DRAIN   = 1'b1;

    logic state_reg;
    logic state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_COLLECT:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (!status.group_close)
                    begin
                        cmd.store_byte = 1'b1;
                    end
                    else if (!status.count_zero)
                    begin
                        cmd.start_drain = 1'b1;
                        state_next      = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (status.out_slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.emit_last)
                    begin
                        cmd.clear_count = 1'b1;
                        state_next      = ST_COLLECT;
                    end
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

endmodule

[rtl/sbp_datapath.sv]
// Datapath for the seven-bit packing decoder: group buffer, overflow byte,
// drain index and output register. Depends on sbp_pkg.
module sbp_datapath
    import sbp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [BYTE_W-1:0]   coded_byte,
    input  logic                message_end,
    input  sbp_cmd_t            cmd,
    output sbp_status_t         status,
    output logic [BYTE_W-1:0]   plain_byte,
    output logic                run_end,
    output logic                message_done,
    output logic                out_valid,
    input  logic                out_stall
);

    logic [DATA_W-1:0]  group_reg [GROUP_SIZE];
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] idx_reg;
    logic [BYTE_W-1:0]  ovf_reg;
    logic               end_reg;
    logic [BYTE_W-1:0]  plain_reg;
    logic               run_end_reg;
    logic               done_reg;
    logic               out_valid_reg;

    logic               emit_last;

    assign emit_last = (idx_reg == COUNT_W'(count_reg - COUNT_W'(1)));

    assign status.group_close   = message_end || (count_reg == COUNT_W'(GROUP_SIZE));
    assign status.count_zero    = (count_reg == '0);
    assign status.emit_last     = emit_last;
    assign status.out_slot_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.store_byte)
        begin
            group_reg[count_reg] <= coded_byte[DATA_W-1:0];
        end
        if (cmd.start_drain)
        begin
            ovf_reg <= coded_byte;
            end_reg <= message_end;
        end
        if (cmd.emit)
        begin
            plain_reg   <= {ovf_reg[idx_reg], group_reg[idx_reg]};
            run_end_reg <= emit_last;
            done_reg    <= emit_last && end_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.store_byte)
            begin
                count_reg <= COUNT_W'(count_reg + COUNT_W'(1));
            end
            else if (cmd.clear_count)
            begin
                count_reg <= '0;
            end

            if (cmd.start_drain)
            begin
                idx_reg <= '0;
            end
            else if (cmd.emit)
            begin
                idx_reg <= COUNT_W'(idx_reg + COUNT_W'(1));
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign plain_byte   = plain_reg;
    assign run_end      = run_end_reg;
    assign message_done = done_reg;
    assign out_valid    = out_valid_reg;

endmodule

[rtl/seven_bit_packing_decoder_core.sv]
// Top level of the seven-bit packing decoder: controller plus datapath.
// Depends on sbp_pkg, sbp_ctrl and sbp_datapath.
//
// Usage:
//   Input channel (coded_byte, message_end, in_valid, in_stall): one coded
//   byte per transfer. Data bytes are buffered, up to seven per group; a
//   group's eighth byte, or any byte with message_end set, is its overflow
//   byte and releases the buffered bytes with their top bits restored.
//   Output channel (plain_byte, run_end, message_done, out_valid,
//   out_stall): one restored byte per transfer; run_end marks the last
//   byte released by an input, message_done the last byte of a message.
//   Order: a closing byte moves the controller from collect to drain, and
//   each release is loaded into the output register. A data byte is
//   taken without holding the input; a closing byte with n buffered bytes
//   holds the input while the drain counter walks the group buffer, one
//   output register load per cycle while the output does not stall.
//   Input is taken again while the last released byte still waits in the
//   output register. A closing byte with an empty buffer releases nothing.
//   Reset empties the buffer and the output register. A stall on the
//   output holds the output register and pauses the drain.
module seven_bit_packing_decoder_core
    import sbp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [BYTE_W-1:0] coded_byte,
    input  logic              message_end,
    input  logic              in_valid,
    output logic              in_stall,
    output logic [BYTE_W-1:0] plain_byte,
    output logic              run_end,
    output logic              message_done,
    output logic              out_valid,
    input  logic              out_stall
);

    sbp_cmd_t    cmd;
    sbp_status_t status;

    sbp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    sbp_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .coded_byte   (coded_byte),
        .message_end  (message_end),
        .cmd          (cmd),
        .status       (status),
        .plain_byte   (plain_byte),
        .run_end      (run_end),
        .message_done (message_done),
        .out_valid    (out_valid),
        .out_stall    (out_stall)
    );

    a_drain_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_drain |=> in_stall)
        else $error("input not held after drain start");

    a_last_emit_reopens: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && status.emit_last) |=> (!in_stall && out_valid && run_end))
        else $error("final release did not reopen input");

    a_done_implies_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && message_done) |-> run_end)
        else $error("message_done without run_end");

    a_emit_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (in_stall && !cmd.store_byte && !cmd.start_drain))
        else $error("release while input open");

endmodule
